/* hdl/assert_macros.svh */
// Assertion macros for the RTL; included by the DES block encrypt unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) (!rst_n) |=> (prop)) \
    else $error("assertion failed after reset");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_RST(label, clk, rst_n, prop)
`endif
`endif

/* hdl/des_pkg.sv */
// ----------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes and the round function for the DES engine.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned LastRound = 15;
  localparam int unsigned HalfKeyBits = 28;
  localparam int unsigned RoundKeyBits = 48;

  typedef logic [63:0] blk_t;
  typedef logic [55:0] cd_t;
  typedef logic [47:0] rkey_t;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    cd_t         cd;
  } rnd_t;

  typedef logic [7:0] tab64_t [64];

  localparam tab64_t TabIp = '{
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9, 8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7};

  localparam tab64_t TabFp = '{
    8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
    8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
    8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
    8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
    8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
    8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
    8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
    8'd33, 8'd1, 8'd41, 8'd9, 8'd49, 8'd17, 8'd57, 8'd25};

  localparam logic [7:0] TabE [48] = '{
    8'd32, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
    8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
    8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1};

  localparam logic [7:0] TabP [32] = '{
    8'd16, 8'd7, 8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1, 8'd15, 8'd23, 8'd26, 8'd5, 8'd18, 8'd31, 8'd10,
    8'd2, 8'd8, 8'd24, 8'd14, 8'd32, 8'd27, 8'd3, 8'd9,
    8'd19, 8'd13, 8'd30, 8'd6, 8'd22, 8'd11, 8'd4, 8'd25};

  localparam logic [7:0] TabPc1 [56] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9, 8'd1, 8'd58, 8'd50, 8'd42, 8'd34,
    8'd26, 8'd18, 8'd10, 8'd2, 8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6, 8'd61, 8'd53, 8'd45, 8'd37,
    8'd29, 8'd21, 8'd13, 8'd5, 8'd28, 8'd20, 8'd12, 8'd4};

  localparam logic [7:0] TabPc2 [48] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1, 8'd5, 8'd3, 8'd28, 8'd15, 8'd6, 8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4, 8'd26, 8'd8, 8'd16, 8'd7, 8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32};

  localparam logic [1:0] TabRot [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

  localparam logic [3:0] TabSbox [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12,
      4'd5, 4'd9, 4'd0, 4'd7, 4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8, 4'd4, 4'd1, 4'd14, 4'd8,
      4'd13, 4'd6, 4'd2, 4'd11, 4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7, 4'd5, 4'd11, 4'd3, 4'd14,
      4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13,
      4'd12, 4'd0, 4'd5, 4'd10, 4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5, 4'd0, 4'd14, 4'd7, 4'd11,
      4'd10, 4'd4, 4'd13, 4'd1, 4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2, 4'd11, 4'd6, 4'd7, 4'd12,
      4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7,
      4'd11, 4'd4, 4'd2, 4'd8, 4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1, 4'd13, 4'd6, 4'd4, 4'd9,
      4'd8, 4'd15, 4'd3, 4'd0, 4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7, 4'd4, 4'd15, 4'd14, 4'd3,
      4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5,
      4'd11, 4'd12, 4'd4, 4'd15, 4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9, 4'd10, 4'd6, 4'd9, 4'd0,
      4'd12, 4'd11, 4'd7, 4'd13, 4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd11,
      4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15,
      4'd13, 4'd0, 4'd14, 4'd9, 4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2, 4'd1, 4'd11,
      4'd10, 4'd13, 4'd7, 4'd8, 4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd15, 4'd0, 4'd9,
      4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4,
      4'd14, 4'd7, 4'd5, 4'd11, 4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8, 4'd9, 4'd14, 4'd15, 4'd5,
      4'd2, 4'd8, 4'd12, 4'd3, 4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10, 4'd11, 4'd14, 4'd1, 4'd7,
      4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7,
      4'd5, 4'd10, 4'd6, 4'd1, 4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6, 4'd1, 4'd4, 4'd11, 4'd13,
      4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7, 4'd9, 4'd5, 4'd0, 4'd15,
      4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14,
      4'd5, 4'd0, 4'd12, 4'd7, 4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4, 4'd1,
      4'd9, 4'd12, 4'd14, 4'd2, 4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13, 4'd15, 4'd12, 4'd9, 4'd0,
      4'd3, 4'd5, 4'd6, 4'd11}};

  // Table entries count from 1 at the MSB of the source word.
  function automatic blk_t perm64(blk_t x, tab64_t tab);
    blk_t r;
    for (int i = 0; i < 64; i++) begin
      r[63-i] = x[64-int'(tab[i])];
    end
    return r;
  endfunction

  function automatic cd_t pc1(blk_t k);
    cd_t r;
    for (int i = 0; i < 56; i++) begin
      r[55-i] = k[64-int'(TabPc1[i])];
    end
    return r;
  endfunction

  function automatic rkey_t pc2(cd_t cd);
    rkey_t r;
    for (int i = 0; i < 48; i++) begin
      r[47-i] = cd[56-int'(TabPc2[i])];
    end
    return r;
  endfunction

  function automatic logic [27:0] rot28(logic [27:0] v, logic [1:0] s);
    logic [27:0] r;
    r = (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
    return r;
  endfunction

  function automatic cd_t rot_cd(cd_t cd, logic [1:0] s);
    cd_t r;
    r = {rot28(cd[55:28], s), rot28(cd[27:0], s)};
    return r;
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] r, rkey_t k);
    rkey_t       x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) begin
      x[47-i] = r[32-int'(TabE[i])];
    end
    x = x ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = TabSbox[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) begin
      p[31-i] = s[32-int'(TabP[i])];
    end
    return p;
  endfunction

endpackage

/* hdl/des_round.sv */
// ----------------------------------------------------------------------------
// DES round stage
// One Feistel round and its key rotation, with a registered output and valid.
// ----------------------------------------------------------------------------
module des_round
  import des_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [3:0] idx_i,
  input  logic       valid_i,
  input  rnd_t       data_i,
  output logic       valid_o,
  output rnd_t       data_o
);

  logic valid_q;
  rnd_t data_d, data_q;
  cd_t  cd_rot;
  logic [31:0] nl;

  always_comb begin
    cd_rot = rot_cd(data_i.cd, TabRot[idx_i]);
    nl = data_i.left ^ feistel(data_i.right, pc2(cd_rot));
    data_d.cd = cd_rot;
    // last round keeps the halves unswapped
    if (idx_i == 4'(LastRound)) begin
      data_d.left  = nl;
      data_d.right = data_i.right;
    end else begin
      data_d.left  = data_i.right;
      data_d.right = nl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/des_block_encrypt_unit.sv */
// ----------------------------------------------------------------------------
// DES block encrypt unit
// Streaming DES encryption with an on-the-fly key schedule.
// ----------------------------------------------------------------------------
// Usage: write the 64-bit key on cfg_we_i/cfg_wdata_i while the pipe is empty.
// Plaintext words enter on s_axis_*, ciphertext words leave on m_axis_*.
// Bit 63 of each word is DES bit 1.
// Pipeline: one input stage (IP and PC-1), sixteen round stages, one output
// stage (FP). Throughput is one word per cycle unless the output stalls;
// each round stage holds one word.
// The whole pipe advances together; when m_axis_tready is low and the output
// holds a word, every stage holds and s_axis_tready drops, so nothing is lost.
// Bubbles in the pipe stay in place while the output is stalled.
// Reset clears all valid bits and the key to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module des_block_encrypt_unit
  import des_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] plaintext
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [63:0] ciphertext
);

  blk_t key_q;
  logic en;
  logic in_valid_q, out_valid_q;
  rnd_t in_data_q;
  blk_t out_data_q;
  blk_t ip_blk;
  logic v [NumRounds+1];
  rnd_t d [NumRounds+1];

  // advance when the output slot is free or being drained
  assign en = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign ip_blk = perm64(s_axis_tdata, TabIp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q  <= s_axis_tvalid;
      out_valid_q <= v[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_data_q.left  <= ip_blk[63:32];
      in_data_q.right <= ip_blk[31:0];
      in_data_q.cd    <= pc1(key_q);
      out_data_q      <= perm64({d[NumRounds].left, d[NumRounds].right}, TabFp);
    end
  end

  assign v[0] = in_valid_q;
  assign d[0] = in_data_q;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    des_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (4'(g)),
      .valid_i(v[g]),
      .data_i (d[g]),
      .valid_o(v[g+1]),
      .data_o (d[g+1])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_CLK(a_ready_when_empty, clk_i, rst_ni, !out_valid_q |-> s_axis_tready)
  `ASSERT_CLK(a_hold_stall, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
  `ASSERT_CLK(a_in_to_stage, clk_i, rst_ni,
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
  `ASSERT_RST(a_rst_empty, clk_i, rst_ni, !m_axis_tvalid && !in_valid_q)

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// DES block encrypt unit testbench
// Streams plaintext words through the engine under several keys, with bursty
// input and a stalling output, and checks every ciphertext word against a
// typed-in value or an independent DES model, kept in order in a queue.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import des_pkg::*;

  localparam int unsigned PipeDepth = 18;
  localparam int unsigned NumRandom = 1600;

  // Standard DES tables, kept locally so the model is independent of the DUT.
  localparam byte unsigned IpTab [64] = '{
    58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
    62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
    57, 49, 41, 33, 25, 17, 9, 1, 59, 51, 43, 35, 27, 19, 11, 3,
    61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7};
  localparam byte unsigned FpTab [64] = '{
    40, 8, 48, 16, 56, 24, 64, 32, 39, 7, 47, 15, 55, 23, 63, 31,
    38, 6, 46, 14, 54, 22, 62, 30, 37, 5, 45, 13, 53, 21, 61, 29,
    36, 4, 44, 12, 52, 20, 60, 28, 35, 3, 43, 11, 51, 19, 59, 27,
    34, 2, 42, 10, 50, 18, 58, 26, 33, 1, 41, 9, 49, 17, 57, 25};
  localparam byte unsigned ETab [48] = '{
    32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9, 8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
    16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25, 24, 25, 26, 27, 28, 29, 28, 29,
    30, 31, 32, 1};
  localparam byte unsigned PTab [32] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
    2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25};
  localparam byte unsigned Pc1Tab [56] = '{
    57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
    10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
    14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4};
  localparam byte unsigned Pc2Tab [48] = '{
    14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10, 23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
    41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48, 44, 49, 39, 56, 34, 53, 46, 42, 50, 36,
    29, 32};
  localparam byte unsigned ShiftTab [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};
  localparam byte unsigned SboxTab [8][64] = '{
    '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7, 0, 15, 7, 4, 14, 2, 13, 1,
      10, 6, 12, 11, 9, 5, 3, 8, 4, 1, 14, 8, 13, 6, 2, 11, 15, 12, 9, 7, 3, 10, 5, 0,
      15, 12, 8, 2, 4, 9, 1, 7, 5, 11, 3, 14, 10, 0, 6, 13},
    '{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10, 3, 13, 4, 7, 15, 2, 8, 14,
      12, 0, 1, 10, 6, 9, 11, 5, 0, 14, 7, 11, 10, 4, 13, 1, 5, 8, 12, 6, 9, 3, 2, 15,
      13, 8, 10, 1, 3, 15, 4, 2, 11, 6, 7, 12, 0, 5, 14, 9},
    '{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8, 13, 7, 0, 9, 3, 4, 6, 10,
      2, 8, 5, 14, 12, 11, 15, 1, 13, 6, 4, 9, 8, 15, 3, 0, 11, 1, 2, 12, 5, 10, 14, 7,
      1, 10, 13, 0, 6, 9, 8, 7, 4, 15, 14, 3, 11, 5, 2, 12},
    '{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15, 13, 8, 11, 5, 6, 15, 0, 3,
      4, 7, 2, 12, 1, 10, 14, 9, 10, 6, 9, 0, 12, 11, 7, 13, 15, 1, 3, 14, 5, 2, 8, 4,
      3, 15, 0, 6, 10, 1, 13, 8, 9, 4, 5, 11, 12, 7, 2, 14},
    '{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9, 14, 11, 2, 12, 4, 7, 13, 1,
      5, 0, 15, 10, 3, 9, 8, 6, 4, 2, 1, 11, 10, 13, 7, 8, 15, 9, 12, 5, 6, 3, 0, 14,
      11, 8, 12, 7, 1, 14, 2, 13, 6, 15, 0, 9, 10, 4, 5, 3},
    '{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11, 10, 15, 4, 2, 7, 12, 9, 5,
      6, 1, 13, 14, 0, 11, 3, 8, 9, 14, 15, 5, 2, 8, 12, 3, 7, 0, 4, 10, 1, 13, 11, 6,
      4, 3, 2, 12, 9, 5, 15, 10, 11, 14, 1, 7, 6, 0, 8, 13},
    '{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1, 13, 0, 11, 7, 4, 9, 1, 10,
      14, 3, 5, 12, 2, 15, 8, 6, 1, 4, 11, 13, 12, 3, 7, 14, 10, 15, 6, 8, 0, 5, 9, 2,
      6, 11, 13, 8, 1, 4, 10, 7, 9, 5, 0, 15, 14, 2, 3, 12},
    '{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7, 1, 15, 13, 8, 10, 3, 7, 4,
      12, 5, 6, 11, 0, 14, 9, 2, 7, 11, 4, 1, 9, 12, 14, 2, 0, 6, 10, 13, 15, 3, 5, 8,
      2, 1, 14, 7, 4, 10, 8, 13, 15, 12, 9, 0, 3, 5, 6, 11}};

  typedef struct {
    bit        set_key;   // write the key before this row
    bit [63:0] key;
    bit [63:0] plain;
    bit        known;     // ciphertext typed in
    bit [63:0] cipher;
  } vector_t;

  // Textbook vectors plus extremes, weak keys and parity-only key changes.
  localparam int NumVec = 12;
  vector_t vectors [NumVec] = '{
    '{1'b0, 64'h0, 64'h0, 1'b1, 64'h8CA64DE9C1B123A7},
    '{1'b0, 64'h0, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{1'b1, 64'h0101010101010101, 64'h0, 1'b1, 64'h8CA64DE9C1B123A7},
    '{1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h7359B2163E4EDC58},
    '{1'b0, 64'h0, 64'h0, 1'b0, 64'h0},
    '{1'b1, 64'h133457799BBCDFF1, 64'h0123456789ABCDEF, 1'b1, 64'h85E813540F0AB405},
    '{1'b1, 64'h123456789ABCDEF0, 64'h0123456789ABCDEF, 1'b0, 64'h0},
    '{1'b1, 64'h3000000000000000, 64'h1000000000000001, 1'b1, 64'h958E6E627A05557B},
    '{1'b1, 64'hFEFEFEFEFEFEFEFE, 64'h8000000000000001, 1'b0, 64'h0},
    '{1'b1, 64'h1F1F1F1F0E0E0E0E, 64'h5555555555555555, 1'b0, 64'h0},
    '{1'b1, 64'hE0E0E0E0F1F1F1F1, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0},
    '{1'b1, 64'h8000000000000000, 64'h0000000000000001, 1'b0, 64'h0}};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // [63:0] plaintext
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // [63:0] ciphertext

  bit [63:0] model_key;
  bit [63:0] cipher_q [$];
  int        fails;

  des_block_encrypt_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Output bit i (MSB first) takes source bit tab[i], counting 1 at the MSB.
  function automatic bit [63:0] pick(bit [63:0] x, int w, byte unsigned tab [], int n);
    bit [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r = {r[62:0], x[w - tab[i]]};
    return r;
  endfunction

  function automatic bit [27:0] rotl28(bit [27:0] v, int s);
    return (v << s) | (v >> (28 - s));
  endfunction

  function automatic bit [63:0] des_encrypt(bit [63:0] key, bit [63:0] plain);
    byte unsigned ip [] = IpTab, fp [] = FpTab, et [] = ETab, pt [] = PTab;
    byte unsigned p1 [] = Pc1Tab, p2 [] = Pc2Tab;
    bit [55:0] cd;
    bit [27:0] c, d;
    bit [63:0] blk, t;
    bit [47:0] rk, x;
    bit [31:0] l, r, s, f, nl;
    bit [5:0]  six;
    t = pick(key, 64, p1, 56);
    cd = t[55:0];
    c = cd[55:28];
    d = cd[27:0];
    blk = pick(plain, 64, ip, 64);
    l = blk[63:32];
    r = blk[31:0];
    for (int i = 0; i < 16; i++) begin
      c = rotl28(c, ShiftTab[i]);
      d = rotl28(d, ShiftTab[i]);
      t = pick({8'h00, c, d}, 56, p2, 48);
      rk = t[47:0];
      t = pick({32'h0, r}, 32, et, 48);
      x = t[47:0] ^ rk;
      for (int b = 0; b < 8; b++) begin
        six = x[47 - 6 * b -: 6];
        s[31 - 4 * b -: 4] = 4'(SboxTab[b][{six[5], six[0]} * 16 + six[4:1]]);
      end
      t = pick({32'h0, s}, 32, pt, 32);
      f = t[31:0];
      nl = l ^ f;
      if (i != 15) begin
        l = r;
        r = nl;
      end else begin
        l = nl;
      end
    end
    return pick({l, r}, 64, fp, 64);
  endfunction

  // Key writes only with the pipe empty.
  task automatic load_key(bit [63:0] key);
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= key;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_key = key;
  endtask

  task automatic send_word(bit [63:0] plain, bit known, bit [63:0] cipher);
    cipher_q.push_back(known ? cipher : des_encrypt(model_key, plain));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= plain;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Receiver: stall modes change every so often.
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(200, 20);
      end
      left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(3) != 0);
        2: m_axis_tready <= ($urandom_range(1) != 0);
        default: m_axis_tready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  // Check each ciphertext word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        $error("ciphertext: unexpected word %h", m_axis_tdata);
        fails++;
      end else begin
        bit [63:0] want;
        want = cipher_q.pop_front();
        if (m_axis_tdata !== want) begin
          $error("ciphertext: expected %h, got %h", want, m_axis_tdata);
          fails++;
        end
      end
    end
  end

  initial begin
    int burst, wait_n;
    bit [63:0] key;
    // drop reset at time zero so the asynchronous reset sees an edge
    rst_ni = 1'b0;
    model_key = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (vectors[i]) begin
      if (vectors[i].set_key) begin
        idle_cycles(1);
        load_key(vectors[i].key);
      end
      send_word(vectors[i].plain, vectors[i].known, vectors[i].cipher);
    end
    idle_cycles(1);
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: key = 64'h0;
        1: key = 64'hFFFFFFFFFFFFFFFF;
        default: key = {$urandom, $urandom};
      endcase
      load_key(key);
      for (int n = 0; n < NumRandom / 8; ) begin
        burst = $urandom_range(40, 1);
        for (int b = 0; b < burst && n < NumRandom / 8; b++, n++) begin
          send_word({$urandom, $urandom}, 1'b0, '0);
        end
        wait_n = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        idle_cycles(wait_n);
      end
      idle_cycles(1);
    end
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
    if (fails == 0 && cipher_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
